FILE: hw/rtl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg: shared constants of the priority scheduler with aging
// Default sizes, field widths and reset values used by the scheduler core
// and its port checker.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_ID_BITS    = 16;
  localparam int DEF_STAMP_BITS = 16;

  localparam int SEV_W      = 2;
  localparam int ARRIVE_W   = 2;
  localparam int MAX_WAIT_W = 8;
  localparam int OUT_ID_W   = 16;
  localparam int DROP_W     = 2;
  localparam int QCOUNT_W   = 5;

  localparam logic [MAX_WAIT_W-1:0] MAX_WAIT_RESET = 8'd3;

endpackage

FILE: hw/rtl/psa_ram.sv
// ----------------------------------------------------------------------------
// psa_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/priority_scheduler_with_aging.sv
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging: severity queue with an age limit
// A tick's result waits while the prior result is stalled on the output.
// One RAM read a cycle serves the age check, the search and the gap shift.
// Throughput: one tick per such pass; a new tick is taken while a result waits.
// Synchronous reset empties the queue, zeroes the tick, sets the next id to one
// and max_wait to three. Entry storage needs no clearing pass.
// ----------------------------------------------------------------------------
module priority_scheduler_with_aging #(
  parameter int CAPACITY   = psa_pkg::DEF_CAPACITY,
  parameter int ID_BITS    = psa_pkg::DEF_ID_BITS,
  parameter int STAMP_BITS = psa_pkg::DEF_STAMP_BITS
) (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [psa_pkg::ARRIVE_W-1:0]  arrival_count,
  input  logic [psa_pkg::SEV_W-1:0]     severity_a,
  input  logic [psa_pkg::SEV_W-1:0]     severity_b,
  input  logic [psa_pkg::SEV_W-1:0]     severity_c,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          served,
  output logic [psa_pkg::OUT_ID_W-1:0]  served_id,
  output logic [psa_pkg::SEV_W-1:0]     served_severity,
  output logic                          by_age,
  output logic [psa_pkg::DROP_W-1:0]    dropped,
  output logic [psa_pkg::QCOUNT_W-1:0]  queue_count,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psa_pkg::MAX_WAIT_W-1:0] cfg_data
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int SEV_W   = psa_pkg::SEV_W;
  localparam int ENTRY_W = SEV_W + ID_BITS + STAMP_BITS;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_AGE_RD  = 3'd1;
  localparam logic [2:0] S_AGE_CHK = 3'd2;
  localparam logic [2:0] S_ADD     = 3'd3;
  localparam logic [2:0] S_SCAN    = 3'd4;
  localparam logic [2:0] S_SHIFT   = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]                        state;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  rp;
  logic [CNT_W-1:0]                  ppos;
  logic                              pv;
  logic                              aged;
  logic [psa_pkg::ARRIVE_W-1:0]      k;
  logic [psa_pkg::ARRIVE_W-1:0]      n;
  logic [SEV_W-1:0]                  sev_a;
  logic [SEV_W-1:0]                  sev_b;
  logic [SEV_W-1:0]                  sev_c;
  logic [STAMP_BITS-1:0]             tick;
  logic [ID_BITS-1:0]                next_id;
  logic [psa_pkg::MAX_WAIT_W-1:0]    max_wait;

  logic                              res_served;
  logic                              res_by_age;
  logic [ID_BITS-1:0]                res_id;
  logic [SEV_W-1:0]                  res_sev;
  logic [psa_pkg::DROP_W-1:0]        res_dropped;

  logic [CNT_W-1:0]                  best_pos;
  logic [SEV_W-1:0]                  best_sev;
  logic [ID_BITS-1:0]                best_id;

  logic                              ram_we;
  logic [IDX_W-1:0]                  ram_waddr;
  logic [ENTRY_W-1:0]                ram_wdata;
  logic [IDX_W-1:0]                  ram_raddr;
  logic [ENTRY_W-1:0]                ram_rdata;

  logic [SEV_W-1:0]                  rd_sev;
  logic [ID_BITS-1:0]                rd_id;
  logic [STAMP_BITS-1:0]             rd_stamp;
  logic [STAMP_BITS-1:0]             wait_ticks;
  logic                              issue;
  logic [CNT_W-1:0]                  pos_m1;
  logic [SEV_W-1:0]                  cur_sev;

  psa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_sev     = ram_rdata[ENTRY_W-1 -: SEV_W];
  assign rd_id      = ram_rdata[ID_BITS+STAMP_BITS-1 : STAMP_BITS];
  assign rd_stamp   = ram_rdata[STAMP_BITS-1:0];
  assign wait_ticks = tick - rd_stamp;
  assign issue      = (rp != count);
  assign pos_m1     = ppos - 1'b1;
  assign in_stall   = (state != S_IDLE);
  assign cfg_ready  = 1'b1;

  always_comb begin
    unique case (k)
      2'd0:    cur_sev = sev_a;
      2'd1:    cur_sev = sev_b;
      default: cur_sev = sev_c;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = {cur_sev, next_id, tick};
    ram_raddr = '0;
    unique case (state)
      S_ADD: begin
        ram_we = (k != n) && (count != CAP_CNT);
      end
      S_SCAN: begin
        ram_raddr = rp[IDX_W-1:0];
      end
      S_SHIFT: begin
        ram_raddr = rp[IDX_W-1:0];
        ram_we    = pv;
        ram_waddr = pos_m1[IDX_W-1:0];
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_wait <= psa_pkg::MAX_WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_wait <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      tick      <= '0;
      next_id   <= ID_BITS'(1);
      out_valid <= 1'b0;
      pv        <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            n           <= arrival_count;
            sev_a       <= severity_a;
            sev_b       <= severity_b;
            sev_c       <= severity_c;
            k           <= '0;
            aged        <= 1'b0;
            res_served  <= 1'b0;
            res_by_age  <= 1'b0;
            res_id      <= '0;
            res_sev     <= '0;
            res_dropped <= '0;
            state       <= (count != '0) ? S_AGE_RD : S_ADD;
          end
        end
        S_AGE_RD: begin
          state <= S_AGE_CHK;
        end
        S_AGE_CHK: begin
          if (wait_ticks >= STAMP_BITS'(max_wait)) begin
            res_served <= 1'b1;
            res_by_age <= 1'b1;
            res_id     <= rd_id;
            res_sev    <= rd_sev;
            aged       <= 1'b1;
            rp         <= CNT_W'(1);
            pv         <= 1'b0;
            state      <= S_SHIFT;
          end else begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (k == n) begin
            if (aged || count == '0) begin
              state <= S_DONE;
            end else begin
              rp    <= '0;
              pv    <= 1'b0;
              state <= S_SCAN;
            end
          end else begin
            if (count != CAP_CNT) begin
              count   <= count + 1'b1;
              next_id <= next_id + 1'b1;
            end else begin
              res_dropped <= res_dropped + 1'b1;
            end
            k <= k + 1'b1;
          end
        end
        S_SCAN: begin
          if (pv && (ppos == '0 || rd_sev > best_sev)) begin
            best_pos <= ppos;
            best_sev <= rd_sev;
            best_id  <= rd_id;
          end
          pv   <= issue;
          ppos <= rp;
          if (issue) begin
            rp <= rp + 1'b1;
          end
          if (!issue && !pv) begin
            res_served <= 1'b1;
            res_id     <= best_id;
            res_sev    <= best_sev;
            rp         <= best_pos + 1'b1;
            state      <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          pv   <= issue;
          ppos <= rp;
          if (issue) begin
            rp <= rp + 1'b1;
          end
          if (!issue && !pv) begin
            count <= count - 1'b1;
            state <= aged ? S_ADD : S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            served          <= res_served;
            served_id       <= psa_pkg::OUT_ID_W'(res_id);
            served_severity <= res_sev;
            by_age          <= res_by_age;
            dropped         <= res_dropped;
            queue_count     <= psa_pkg::QCOUNT_W'(count);
            out_valid       <= 1'b1;
            tick            <= tick + 1'b1;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/psa_checker.sv
// ----------------------------------------------------------------------------
// psa_checker: port checker for the priority scheduler with aging
// Watches the top-level ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module psa_checker #(
  parameter int CAPACITY = psa_pkg::DEF_CAPACITY
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          served,
  input logic [psa_pkg::OUT_ID_W-1:0]  served_id,
  input logic [psa_pkg::SEV_W-1:0]     served_severity,
  input logic                          by_age,
  input logic [psa_pkg::DROP_W-1:0]    dropped,
  input logic [psa_pkg::QCOUNT_W-1:0]  queue_count
);

  localparam logic [psa_pkg::QCOUNT_W-1:0] QC_FULL    = psa_pkg::QCOUNT_W'(CAPACITY);
  localparam logic [psa_pkg::QCOUNT_W-1:0] QC_FULL_M1 = psa_pkg::QCOUNT_W'(CAPACITY - 1);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result was withdrawn.");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Input was not stalled while a tick is in progress.");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !served |-> served_id == '0 && served_severity == '0 && !by_age)
    else $error("Result without a served entry carries nonzero fields.");

  a_age_served: assert property (@(posedge clk) disable iff (rst)
    out_valid && by_age |-> served)
    else $error("Aging flag set without a served entry.");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped != '0 |-> queue_count == QC_FULL || queue_count == QC_FULL_M1)
    else $error("Arrivals dropped while the queue was not full.");

endmodule

bind priority_scheduler_with_aging psa_checker #(
  .CAPACITY (CAPACITY)
) u_psa_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .served          (served),
  .served_id       (served_id),
  .served_severity (served_severity),
  .by_age          (by_age),
  .dropped         (dropped),
  .queue_count     (queue_count)
);

FILE: tb/priority_scheduler_with_aging_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging_tb: self-checking bench for the aging scheduler
// Ticks of arrivals go in over the valid/stall input channel while the bench
// keeps its own copy of the severity queue, tick counter and id counter to
// work out each tick's outcome. Every result transfer is compared field by
// field with the oldest outstanding outcome. A short directed table comes
// first, then random phases under several max_wait settings with light,
// balanced and heavy load.
// ----------------------------------------------------------------------------
module priority_scheduler_with_aging_tb;

  localparam int QUEUE_DEPTH   = psa_pkg::DEF_CAPACITY;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS   = 200;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef logic [psa_pkg::DEF_ID_BITS-1:0]    ident_t;
  typedef logic [psa_pkg::DEF_STAMP_BITS-1:0] stamp_t;

  typedef struct packed {
    logic [psa_pkg::SEV_W-1:0] sev;
    ident_t                    ident;
    stamp_t                    stamp;
  } waiting_entry_t;

  typedef struct packed {
    logic [psa_pkg::ARRIVE_W-1:0] count;
    logic [psa_pkg::SEV_W-1:0]    sev_a;
    logic [psa_pkg::SEV_W-1:0]    sev_b;
    logic [psa_pkg::SEV_W-1:0]    sev_c;
  } tick_input_t;

  typedef struct packed {
    logic                         served;
    logic [psa_pkg::OUT_ID_W-1:0] ident;
    logic [psa_pkg::SEV_W-1:0]    sev;
    logic                         by_age;
    logic [psa_pkg::DROP_W-1:0]   dropped;
    logic [psa_pkg::QCOUNT_W-1:0] qcount;
  } tick_outcome_t;

  typedef struct {
    bit                             set_cfg;
    logic [psa_pkg::MAX_WAIT_W-1:0] cfg_value;
    tick_input_t                    stim;
    bit                             typed;
    tick_outcome_t                  want;
  } table_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [psa_pkg::ARRIVE_W-1:0]   arrival_count = '0;
  logic [psa_pkg::SEV_W-1:0]      severity_a = '0;
  logic [psa_pkg::SEV_W-1:0]      severity_b = '0;
  logic [psa_pkg::SEV_W-1:0]      severity_c = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           served;
  logic [psa_pkg::OUT_ID_W-1:0]   served_id;
  logic [psa_pkg::SEV_W-1:0]      served_severity;
  logic                           by_age;
  logic [psa_pkg::DROP_W-1:0]     dropped;
  logic [psa_pkg::QCOUNT_W-1:0]   queue_count;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [psa_pkg::MAX_WAIT_W-1:0] cfg_data = '0;

  waiting_entry_t                 model_queue[$];
  stamp_t                         model_tick;
  ident_t                         model_next_ident;
  logic [psa_pkg::MAX_WAIT_W-1:0] model_max_wait;
  tick_outcome_t                  pending_outcomes[$];
  tick_outcome_t                  expected_outcome;
  table_row_t                     directed_rows[$];
  bit                             idling_on = 1'b1;
  bit                             mismatch_seen = 1'b0;
  int                             hold_left;
  int                             cycle_count;

  priority_scheduler_with_aging dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .arrival_count   (arrival_count),
    .severity_a      (severity_a),
    .severity_b      (severity_b),
    .severity_c      (severity_c),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .served          (served),
    .served_id       (served_id),
    .served_severity (served_severity),
    .by_age          (by_age),
    .dropped         (dropped),
    .queue_count     (queue_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [psa_pkg::DROP_W-1:0] admit_arrivals(input tick_input_t t);
    logic [psa_pkg::DROP_W-1:0] lost;
    waiting_entry_t             fresh;
    int                         k;
    lost = '0;
    for (k = 0; k < t.count; k++) begin
      if (model_queue.size() >= QUEUE_DEPTH) begin
        lost = lost + 1'b1;
      end else begin
        fresh.sev   = (k == 0) ? t.sev_a : (k == 1) ? t.sev_b : t.sev_c;
        fresh.ident = model_next_ident;
        fresh.stamp = model_tick;
        model_queue = {model_queue, fresh};
        model_next_ident = model_next_ident + 1'b1;
      end
    end
    return lost;
  endfunction

  function automatic tick_outcome_t schedule_tick(input tick_input_t t);
    tick_outcome_t outcome;
    stamp_t        waited;
    int            best;
    int            i;
    outcome = '0;
    waited = '0;
    if (model_queue.size() > 0) begin
      waited = model_tick - model_queue[0].stamp;
    end
    if (model_queue.size() > 0 && waited >= model_max_wait) begin
      outcome.served = 1'b1;
      outcome.by_age = 1'b1;
      outcome.ident  = model_queue[0].ident;
      outcome.sev    = model_queue[0].sev;
      model_queue.delete(0);
      outcome.dropped = admit_arrivals(t);
    end else begin
      outcome.dropped = admit_arrivals(t);
      if (model_queue.size() > 0) begin
        best = 0;
        for (i = 1; i < model_queue.size(); i++) begin
          if (model_queue[i].sev > model_queue[best].sev) begin
            best = i;
          end
        end
        outcome.served = 1'b1;
        outcome.ident  = model_queue[best].ident;
        outcome.sev    = model_queue[best].sev;
        model_queue.delete(best);
      end
    end
    model_tick = model_tick + 1'b1;
    outcome.qcount = psa_pkg::QCOUNT_W'(model_queue.size());
    return outcome;
  endfunction

  task automatic add_row(input int set_cfg, input int cfg_value, input int cnt,
                         input int a, input int b, input int c, input int typed,
                         input int srv, input int id, input int sev, input int age,
                         input int drop, input int qc);
    table_row_t r;
    r.set_cfg        = (set_cfg != 0);
    r.cfg_value      = psa_pkg::MAX_WAIT_W'(cfg_value);
    r.stim.count     = psa_pkg::ARRIVE_W'(cnt);
    r.stim.sev_a     = psa_pkg::SEV_W'(a);
    r.stim.sev_b     = psa_pkg::SEV_W'(b);
    r.stim.sev_c     = psa_pkg::SEV_W'(c);
    r.typed          = (typed != 0);
    r.want.served    = (srv != 0);
    r.want.ident     = psa_pkg::OUT_ID_W'(id);
    r.want.sev       = psa_pkg::SEV_W'(sev);
    r.want.by_age    = (age != 0);
    r.want.dropped   = psa_pkg::DROP_W'(drop);
    r.want.qcount    = psa_pkg::QCOUNT_W'(qc);
    directed_rows = {directed_rows, r};
  endtask

  task automatic send_tick(input tick_input_t t, input bit typed, input tick_outcome_t want);
    tick_outcome_t predicted;
    int            gap;
    gap = idling_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    arrival_count <= t.count;
    severity_a    <= t.sev_a;
    severity_b    <= t.sev_b;
    severity_c    <= t.sev_c;
    do @(posedge clk); while (in_stall);
    predicted = schedule_tick(t);
    pending_outcomes = {pending_outcomes, (typed ? want : predicted)};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
  endtask

  task automatic write_max_wait(input logic [psa_pkg::MAX_WAIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_max_wait = value;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatch_seen = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result transfer with no tick outstanding, expected none, actual id %0d",
                 $time, served_id);
        mismatch_seen = 1'b1;
      end else begin
        expected_outcome = pending_outcomes.pop_front();
        check_field("served", 32'(expected_outcome.served), 32'(served));
        check_field("served_id", 32'(expected_outcome.ident), 32'(served_id));
        check_field("served_severity", 32'(expected_outcome.sev), 32'(served_severity));
        check_field("by_age", 32'(expected_outcome.by_age), 32'(by_age));
        check_field("dropped", 32'(expected_outcome.dropped), 32'(dropped));
        check_field("queue_count", 32'(expected_outcome.qcount), 32'(queue_count));
      end
      hold_left = idling_on ? $urandom_range(0, 3) : 0;
      out_stall <= (hold_left > 0);
    end else if (out_valid && out_stall) begin
      hold_left = hold_left - 1;
      if (hold_left <= 0) begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
    $display("priority_scheduler_with_aging_tb: FAIL");
    $finish;
  end

  initial begin
    tick_input_t                    stim;
    int                             load;
    logic [psa_pkg::MAX_WAIT_W-1:0] wait_setting;
    model_tick       = '0;
    model_next_ident = ident_t'(1);
    model_max_wait   = psa_pkg::MAX_WAIT_RESET;

    // Columns: config write, max_wait, arrivals, severities a b c, typed,
    // then served, id, severity, by_age, dropped, queue_count when typed.
    add_row(0,   0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 1, 3, 0, 0, 1, 1, 1, 3, 0, 0, 0);
    add_row(0,   0, 3, 0, 0, 0, 1, 1, 2, 0, 0, 0, 2);
    add_row(0,   0, 1, 0, 3, 3, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 1, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 1, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 1, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 255, 3, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 3, 0, 1, 2, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 3, 3, 3, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 3, 2, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 3, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 3, 0, 0, 3, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 3, 2, 3, 2, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 3, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 3, 3, 2, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(1,   0, 3, 2, 2, 2, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 0, 3, 3, 3, 0, 0, 0, 0, 0, 0, 0);
    add_row(0,   0, 2, 1, 3, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_cfg) begin
        drain_results();
        write_max_wait(directed_rows[r].cfg_value);
      end
      send_tick(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      if (p == 1) begin
        wait_setting = '1;
      end else if (p == 2) begin
        wait_setting = '0;
      end else if (p % 2 == 0) begin
        wait_setting = psa_pkg::MAX_WAIT_W'($urandom_range(0, 255));
      end else begin
        wait_setting = psa_pkg::MAX_WAIT_W'($urandom_range(1, 8));
      end
      write_max_wait(wait_setting);
      load = $urandom_range(0, 2);

      for (int n = 0; n < PHASE_TICKS; n++) begin
        case (load)
          0:       stim.count = psa_pkg::ARRIVE_W'($urandom_range(0, 1));
          1:       stim.count = psa_pkg::ARRIVE_W'($urandom_range(0, 2));
          default: stim.count = psa_pkg::ARRIVE_W'($urandom_range(1, 3));
        endcase
        stim.sev_a = psa_pkg::SEV_W'($urandom_range(0, 3));
        stim.sev_b = psa_pkg::SEV_W'($urandom_range(0, 3));
        stim.sev_c = psa_pkg::SEV_W'($urandom_range(0, 3));
        if ($urandom_range(0, 99) == 0) begin
          drain_results();
        end
        send_tick(stim, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!mismatch_seen) begin
      $display("priority_scheduler_with_aging_tb: PASS");
    end else begin
      $display("priority_scheduler_with_aging_tb: FAIL");
    end
    $finish;
  end

endmodule
